>>> hdl/erot_pkg.sv
`timescale 1ns / 1ps
package erot_pkg;

  localparam int ANGLE_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 2'd2;

  localparam logic signed [ANGLE_W:0] FULL_TURN = 17'sd23040;
  localparam logic [14:0] TURN_Q1 = 15'd5760;
  localparam logic [14:0] TURN_Q2 = 15'd11520;
  localparam logic [14:0] TURN_Q3 = 15'd17280;

  // round(2^30 * pi / 11520)
  localparam logic [31:0] RAD_PER_STEP = 32'd292818;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  localparam logic [2:0] SIN_LAST = 3'd5;
  localparam logic [2:0] COS_LAST = 3'd6;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_TH   = 11'b000_0000_0010,
    ST_X2   = 11'b000_0000_0100,
    ST_LD   = 11'b000_0000_1000,
    ST_HM   = 11'b000_0001_0000,
    ST_DS   = 11'b000_0010_0000,
    ST_DV   = 11'b000_0100_0000,
    ST_UP   = 11'b000_1000_0000,
    ST_SM   = 11'b001_0000_0000,
    ST_SR   = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } trig_st_t;

  // Horner divisors, innermost term first
  function automatic logic [7:0] horner_den(input logic is_cos, input logic [2:0] idx);
    logic [7:0] d;
    d = 8'd1;
    if (is_cos) begin
      case (idx)
        3'd0: d = 8'd182;
        3'd1: d = 8'd132;
        3'd2: d = 8'd90;
        3'd3: d = 8'd56;
        3'd4: d = 8'd30;
        3'd5: d = 8'd12;
        3'd6: d = 8'd2;
        default: d = 8'd1;
      endcase
    end else begin
      case (idx)
        3'd0: d = 8'd156;
        3'd1: d = 8'd110;
        3'd2: d = 8'd72;
        3'd3: d = 8'd42;
        3'd4: d = 8'd20;
        3'd5: d = 8'd6;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

  // ceil(2^k / d) with k = 32 + ceil(log2 d): exact floor quotient for 32-bit dividends
  function automatic logic [32:0] horner_rcp(input logic is_cos, input logic [2:0] idx);
    logic [32:0] m;
    m = 33'd0;
    if (is_cos) begin
      case (idx)
        3'd0: m = 33'(((64'd1 << 40) + 64'd181) / 64'd182);
        3'd1: m = 33'(((64'd1 << 40) + 64'd131) / 64'd132);
        3'd2: m = 33'(((64'd1 << 39) + 64'd89) / 64'd90);
        3'd3: m = 33'(((64'd1 << 38) + 64'd55) / 64'd56);
        3'd4: m = 33'(((64'd1 << 37) + 64'd29) / 64'd30);
        3'd5: m = 33'(((64'd1 << 36) + 64'd11) / 64'd12);
        3'd6: m = 33'(((64'd1 << 33) + 64'd1) / 64'd2);
        default: m = 33'd0;
      endcase
    end else begin
      case (idx)
        3'd0: m = 33'(((64'd1 << 40) + 64'd155) / 64'd156);
        3'd1: m = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
        3'd2: m = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
        3'd3: m = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
        3'd4: m = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
        3'd5: m = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
        default: m = 33'd0;
      endcase
    end
    return m;
  endfunction

  function automatic logic [5:0] horner_sh(input logic is_cos, input logic [2:0] idx);
    logic [5:0] k;
    k = 6'd32;
    if (is_cos) begin
      case (idx)
        3'd0: k = 6'd40;
        3'd1: k = 6'd40;
        3'd2: k = 6'd39;
        3'd3: k = 6'd38;
        3'd4: k = 6'd37;
        3'd5: k = 6'd36;
        3'd6: k = 6'd33;
        default: k = 6'd32;
      endcase
    end else begin
      case (idx)
        3'd0: k = 6'd40;
        3'd1: k = 6'd39;
        3'd2: k = 6'd39;
        3'd3: k = 6'd38;
        3'd4: k = 6'd37;
        3'd5: k = 6'd35;
        default: k = 6'd32;
      endcase
    end
    return k;
  endfunction

endpackage

>>> hdl/erot_trig.sv
`timescale 1ns / 1ps
module erot_trig import erot_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [ANGLE_W-1:0]            cfg_data,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_x,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_x,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_y,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_y,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_z,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_z
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int SH = 30 - TRIG_FRAC_BITS;

  trig_st_t st_r, st_nxt;

  logic [CFG_IDX_W-1:0] axis_r;
  logic [1:0]           quad_r;
  logic [12:0]          r_r;
  logic [64:0]          mul_r;
  logic [30:0]          th_r;
  logic [31:0]          x2_r;
  logic [30:0]          t_r;
  logic [31:0]          num_r;
  logic [2:0]           idx_r;
  logic                 phase_r;
  logic signed [TW-1:0] s_r;
  logic signed [TW-1:0] sn_r [3];
  logic signed [TW-1:0] cs_r [3];

  logic signed [ANGLE_W:0] a0, a1;
  logic [14:0]   w;
  logic [1:0]    q_c;
  logic [12:0]   r_c;
  logic [31:0]   mul_a;
  logic [32:0]   mul_b;
  logic [32:0]   rcp;
  logic [5:0]    rsh;
  logic [64:0]   quo;
  logic [2:0]    last_idx;
  logic signed [TW-1:0] c_c, so_c, co_c;
  logic          wr;

  function automatic logic signed [TW-1:0] rnd(input logic [31:0] v);
    logic [32:0] tmp;
    tmp = {1'b0, v} + (33'd1 << (SH - 1));
    return $signed(tmp[SH+TW-1:SH]);
  endfunction

  assign cfg_ready = (st_r == ST_IDLE);
  assign wr = cfg_valid && cfg_ready && (cfg_index <= CFG_ANGLE_Z);

  always_comb begin
    a0 = {cfg_data[ANGLE_W-1], cfg_data};
    a1 = a0;
    if (a0 < 0) begin
      a1 = a0 + FULL_TURN;
      if (a1 < 0) a1 = a1 + FULL_TURN;
    end else if (a0 >= FULL_TURN) begin
      a1 = a0 - FULL_TURN;
    end
    w = a1[14:0];
    if (w >= TURN_Q3) begin
      q_c = 2'd3;
      r_c = 13'(w - TURN_Q3);
    end else if (w >= TURN_Q2) begin
      q_c = 2'd2;
      r_c = 13'(w - TURN_Q2);
    end else if (w >= TURN_Q1) begin
      q_c = 2'd1;
      r_c = 13'(w - TURN_Q1);
    end else begin
      q_c = 2'd0;
      r_c = 13'(w);
    end
  end

  assign rcp = horner_rcp(phase_r, idx_r);
  assign rsh = horner_sh(phase_r, idx_r);
  assign quo = mul_r >> rsh;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      ST_TH: begin
        mul_a = {19'd0, r_r};
        mul_b = {1'b0, RAD_PER_STEP};
      end
      ST_X2: begin
        mul_a = mul_r[31:0];
        mul_b = {1'b0, mul_r[31:0]};
      end
      ST_HM: begin
        mul_a = x2_r;
        mul_b = {2'b0, t_r};
      end
      ST_DS: begin
        mul_a = mul_r[61:30];
        mul_b = rcp;
      end
      ST_SM: begin
        mul_a = {1'b0, th_r};
        mul_b = {2'b0, t_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign last_idx = phase_r ? COS_LAST : SIN_LAST;

  always_comb begin
    c_c = rnd({1'b0, t_r});
    case (quad_r)
      2'd0: begin so_c = s_r;  co_c = c_c;  end
      2'd1: begin so_c = c_c;  co_c = -s_r; end
      2'd2: begin so_c = -s_r; co_c = -c_c; end
      default: begin so_c = -c_c; co_c = s_r; end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (wr) st_nxt = ST_TH;
      ST_TH:   st_nxt = ST_X2;
      ST_X2:   st_nxt = ST_LD;
      ST_LD:   st_nxt = ST_HM;
      ST_HM:   st_nxt = ST_DS;
      ST_DS:   st_nxt = ST_DV;
      ST_DV:   st_nxt = ST_UP;
      ST_UP: begin
        if (idx_r != last_idx) st_nxt = ST_HM;
        else if (phase_r) st_nxt = ST_FIN;
        else st_nxt = ST_SM;
      end
      ST_SM:   st_nxt = ST_SR;
      ST_SR:   st_nxt = ST_HM;
      ST_FIN:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        sn_r[i] <= '0;
        cs_r[i] <= TW'(1) <<< TRIG_FRAC_BITS;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_FIN) begin
        sn_r[axis_r] <= so_c;
        cs_r[axis_r] <= co_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    unique case (st_r)
      ST_IDLE: begin
        axis_r <= cfg_index;
        quad_r <= q_c;
        r_r    <= r_c;
      end
      ST_X2: th_r <= mul_r[30:0];
      ST_LD: begin
        x2_r    <= mul_r[61:30];
        t_r     <= Q30_ONE[30:0];
        idx_r   <= '0;
        phase_r <= 1'b0;
      end
      ST_DV: num_r <= quo[31:0];
      ST_UP: begin
        t_r   <= (num_r > Q30_ONE) ? '0 : 31'(Q30_ONE - num_r);
        idx_r <= idx_r + 3'd1;
      end
      ST_SR: begin
        s_r     <= rnd(mul_r[61:30]);
        t_r     <= Q30_ONE[30:0];
        idx_r   <= '0;
        phase_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sin_x = sn_r[0];
  assign cos_x = cs_r[0];
  assign sin_y = sn_r[1];
  assign cos_y = cs_r[1];
  assign sin_z = sn_r[2];
  assign cos_z = cs_r[2];

endmodule

>>> hdl/erot_axis.sv
`timescale 1ns / 1ps
module erot_axis import erot_pkg::*; #(
  parameter int COORD_WIDTH    = 24,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_in,
  input  logic signed [COORD_WIDTH-1:0]       p_in,
  input  logic signed [COORD_WIDTH-1:0]       q_in,
  input  logic signed [COORD_WIDTH-1:0]       u_in,
  input  logic signed [TRIG_FRAC_BITS+1:0]    sin_v,
  input  logic signed [TRIG_FRAC_BITS+1:0]    cos_v,
  output logic                                vld_out,
  output logic signed [COORD_WIDTH-1:0]       p_out,
  output logic signed [COORD_WIDTH-1:0]       q_out,
  output logic signed [COORD_WIDTH-1:0]       u_out
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] MAXV =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0] pc_r, qs_r, ps_r, qc_r;
  logic signed [COORD_WIDTH-1:0] u1_r;
  logic v1_r, v2_r;
  logic signed [SW-1:0] d, e, d_sh, e_sh;
  logic signed [COORD_WIDTH-1:0] d_sat, e_sat;

  always_comb begin
    d    = $signed({pc_r[PW-1], pc_r}) - $signed({qs_r[PW-1], qs_r});
    e    = $signed({ps_r[PW-1], ps_r}) + $signed({qc_r[PW-1], qc_r});
    d_sh = d >>> TRIG_FRAC_BITS;
    e_sh = e >>> TRIG_FRAC_BITS;
    if (d_sh > MAXV) d_sat = MAXV[COORD_WIDTH-1:0];
    else if (d_sh < MINV) d_sat = MINV[COORD_WIDTH-1:0];
    else d_sat = d_sh[COORD_WIDTH-1:0];
    if (e_sh > MAXV) e_sat = MAXV[COORD_WIDTH-1:0];
    else if (e_sh < MINV) e_sat = MINV[COORD_WIDTH-1:0];
    else e_sat = e_sh[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r  <= p_in * cos_v;
      qs_r  <= q_in * sin_v;
      ps_r  <= p_in * sin_v;
      qc_r  <= q_in * cos_v;
      u1_r  <= u_in;
      p_out <= d_sat;
      q_out <= e_sat;
      u_out <= u1_r;
    end
  end

  assign vld_out = v2_r;

endmodule

>>> hdl/euler_xyz_point_rotation.sv
`timescale 1ns / 1ps
// Rotates a stream of Q15.8 vertices by three Euler angles, X then Y then Z.
// Input channel in_valid/in_stall carries in_x, in_y, in_z; result channel
// out_valid/out_stall carries out_x, out_y, out_z. A transfer happens when
// valid is high and stall is low.
// Angles are written over cfg_valid/cfg_ready: index 0, 1, 2 for X, Y, Z,
// data in 1/64 degree. A write starts the sine/cosine unit, which has
// one shared multiplier and uses a reciprocal multiply per Horner
// term; cfg_ready and in_stall hold off further writes and vertices until
// it is done. Writes to index 3 are taken and dropped.
// Each axis has two register stages (products, then sum/shift/saturate);
// one vertex per cycle is accepted when not stalled.
// When out_stall is high with a result waiting, the whole pipe holds and
// in_stall rises; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipe and sets all angles to
// zero (sine 0, cosine 1.0).
module euler_xyz_point_rotation import erot_pkg::*; #(
  parameter int COORD_WIDTH    = 24,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [ANGLE_W-1:0]            cfg_data
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
  logic en, take;
  logic vx, vy;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || !cfg_ready;
  assign take     = in_valid && !in_stall;

  erot_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sin_x(sin_x), .cos_x(cos_x), .sin_y(sin_y),
    .cos_y(cos_y), .sin_z(sin_z), .cos_z(cos_z)
  );

  erot_axis #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_ax (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(take),
    .p_in(in_y), .q_in(in_z), .u_in(in_x),
    .sin_v(sin_x), .cos_v(cos_x),
    .vld_out(vx), .p_out(y1), .q_out(z1), .u_out(x1)
  );

  erot_axis #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_ay (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vx),
    .p_in(z1), .q_in(x1), .u_in(y1),
    .sin_v(sin_y), .cos_v(cos_y),
    .vld_out(vy), .p_out(z2), .q_out(x2), .u_out(y2)
  );

  erot_axis #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_az (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vy),
    .p_in(x2), .q_in(y2), .u_in(z2),
    .sin_v(sin_z), .cos_v(cos_z),
    .vld_out(out_valid), .p_out(out_x), .q_out(out_y), .u_out(out_z)
  );

endmodule
